// File: rtl/core/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Opcodes, field widths and the types shared by the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int OpW    = 3;
  localparam int IndexW = 11;
  localparam int ValueW = 32;
  localparam int LenW   = 11;

  localparam logic [OpW-1:0] OP_READ      = 3'd0;
  localparam logic [OpW-1:0] OP_INS_HEAD  = 3'd1;
  localparam logic [OpW-1:0] OP_INS_TAIL  = 3'd2;
  localparam logic [OpW-1:0] OP_INS_INDEX = 3'd3;
  localparam logic [OpW-1:0] OP_DELETE    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_FILL,
    ST_POST
  } state_t;

  typedef enum logic [1:0] {
    K_NONE,
    K_READ,
    K_INSERT,
    K_DELETE
  } kind_t;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic shift_step;
    logic fill;
    logic del_finish;
    logic post;
  } cmd_t;

  typedef struct packed {
    kind_t kind_in;
    kind_t kind_r;
    logic  shift_done;
    logic  out_free;
  } sts_t;

endpackage

// File: rtl/core/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of up to CAPACITY signed 32-bit values with indexed access.
// ----------------------------------------------------------------------------
// Input channel in_*: one item per handshake (valid high, stall low) carrying
// an opcode (read, insert at head, tail or index, delete at index), an index
// and a value. Every item gives exactly one result on out_*: the read value
// and hit flag, whether the list changed, and the length after the item.
// Items are handled one at a time; the next item can be taken in the cycle
// after the result of the last one is posted. A read that hits reads the
// element memory before its result is posted; an item that changes nothing
// goes straight to posting. An insert or delete moves every element behind
// the position by one place through the element memory, one element per
// cycle (read one address while writing the one before); an insert then
// writes the new value at its position, and both then post the result.
// The result register parts the channels: the block accepts a new item while
// a result waits; that item is held in its last step until the receiver
// drops stall. After reset the list is empty; the memory needs no clearing
// because only positions below the length are ever read.
// ----------------------------------------------------------------------------
module indexed_list_store
  import ils_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OpW-1:0]           in_opcode,
  input  logic [IndexW-1:0]        in_item_index,
  input  logic signed [ValueW-1:0] in_item_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ValueW-1:0] out_read_value,
  output logic                     out_read_hit,
  output logic                     out_accepted,
  output logic [LenW-1:0]          out_list_length
);

  cmd_t cmd;
  sts_t sts;

  ils_controller u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  ils_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_item_index  (in_item_index),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_read_hit   (out_read_hit),
    .out_accepted   (out_accepted),
    .out_list_length(out_list_length)
  );

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd_issue, cmd.fill, cmd.post}))
    else $error("more than one step command at once");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in flight");

  a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> (!out_valid || !out_stall))
    else $error("result posted over a stalled result");

  a_fill_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> sts.shift_done)
    else $error("fill issued with shift still pending");
`endif

endmodule

// File: rtl/core/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/ils_datapath.sv
// ----------------------------------------------------------------------------
// ils_datapath
// Element memory, length counter, shift pointers and the result register.
// ----------------------------------------------------------------------------
module ils_datapath
  import ils_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [OpW-1:0]           in_opcode,
  input  logic [IndexW-1:0]        in_item_index,
  input  logic signed [ValueW-1:0] in_item_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ValueW-1:0] out_read_value,
  output logic                     out_read_hit,
  output logic                     out_accepted,
  output logic [LenW-1:0]          out_list_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IndexW) ? CW : IndexW;

  logic [CW-1:0]     count_r, count_nxt;
  kind_t             kind_r, kind_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [ValueW-1:0] value_r, value_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic              wr_vld_r, wr_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ValueW-1:0] rd_value_r, rd_value_nxt;
  logic              hit_r, hit_nxt;
  logic              acc_r, acc_nxt;
  logic [LenW-1:0]   len_r, len_nxt;

  logic [XW-1:0]     idx_x, cnt_x;
  logic              full;
  kind_t             kind_in;
  logic [AW-1:0]     pos_in;
  logic [CW-1:0]     pos_c;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ValueW-1:0] ram_wdata, ram_rdata;

  assign idx_x = XW'(in_item_index);
  assign cnt_x = XW'(count_r);
  assign full  = (count_r == CW'(CAPACITY));

  always_comb begin
    kind_in = K_NONE;
    pos_in  = AW'(idx_x);
    unique case (in_opcode)
      OP_READ: begin
        if (idx_x < cnt_x) kind_in = K_READ;
      end
      OP_INS_HEAD: begin
        pos_in = '0;
        if (!full) kind_in = K_INSERT;
      end
      OP_INS_TAIL: begin
        pos_in = AW'(count_r);
        if (!full) kind_in = K_INSERT;
      end
      OP_INS_INDEX: begin
        if ((idx_x <= cnt_x) && !full) kind_in = K_INSERT;
      end
      OP_DELETE: begin
        if (idx_x < cnt_x) kind_in = K_DELETE;
      end
      default: kind_in = K_NONE;
    endcase
  end

  assign pos_c = CW'(pos_in);

  always_comb begin
    count_nxt   = count_r;
    kind_nxt    = kind_r;
    pos_nxt     = pos_r;
    value_nxt   = value_r;
    src_nxt     = src_r;
    left_nxt    = left_r;
    wr_addr_nxt = wr_addr_r;
    wr_vld_nxt  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wr_addr_r;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = src_r;

    if (cmd.load) begin
      kind_nxt  = kind_in;
      pos_nxt   = pos_in;
      value_nxt = in_item_value;
      if (kind_in == K_INSERT) begin
        left_nxt = count_r - pos_c;
        src_nxt  = AW'(count_r - CW'(1));
      end else begin
        left_nxt = count_r - pos_c - CW'(1);
        src_nxt  = AW'(pos_c + CW'(1));
      end
    end

    if (cmd.rd_issue) begin
      ram_re    = 1'b1;
      ram_raddr = pos_r;
    end

    if (cmd.shift_step) begin
      if (left_r != '0) begin
        ram_re     = 1'b1;
        ram_raddr  = src_r;
        left_nxt   = left_r - CW'(1);
        wr_vld_nxt = 1'b1;
        if (kind_r == K_INSERT) begin
          src_nxt     = src_r - AW'(1);
          wr_addr_nxt = src_r + AW'(1);
        end else begin
          src_nxt     = src_r + AW'(1);
          wr_addr_nxt = src_r - AW'(1);
        end
      end
      if (wr_vld_r) begin
        ram_we = 1'b1;
      end
    end

    if (cmd.fill) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r;
      ram_wdata = value_r;
      count_nxt = count_r + CW'(1);
    end

    if (cmd.del_finish) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    rd_value_nxt  = rd_value_r;
    hit_nxt       = hit_r;
    acc_nxt       = acc_r;
    len_nxt       = len_r;
    if (cmd.post) begin
      out_valid_nxt = 1'b1;
      hit_nxt       = (kind_r == K_READ);
      rd_value_nxt  = (kind_r == K_READ) ? ram_rdata : '0;
      acc_nxt       = (kind_r == K_INSERT) || (kind_r == K_DELETE);
      len_nxt       = cnt_x[LenW-1:0];
    end
  end

  ils_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      kind_r      <= K_NONE;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      kind_r      <= kind_nxt;
      wr_vld_r    <= wr_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    value_r    <= value_nxt;
    src_r      <= src_nxt;
    left_r     <= left_nxt;
    wr_addr_r  <= wr_addr_nxt;
    rd_value_r <= rd_value_nxt;
    hit_r      <= hit_nxt;
    acc_r      <= acc_nxt;
    len_r      <= len_nxt;
  end

  assign sts.kind_in    = kind_in;
  assign sts.kind_r     = kind_r;
  assign sts.shift_done = (left_r == '0) && !wr_vld_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_read_value  = rd_value_r;
  assign out_read_hit    = hit_r;
  assign out_accepted    = acc_r;
  assign out_list_length = len_r;

endmodule

// File: rtl/core/ils_controller.sv
// ----------------------------------------------------------------------------
// ils_controller
// Sequences one item: read, shift, fill and post of the result.
// ----------------------------------------------------------------------------
module ils_controller
  import ils_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (sts.kind_in)
            K_READ:   state_nxt = ST_READ;
            K_INSERT: state_nxt = ST_SHIFT;
            K_DELETE: state_nxt = ST_SHIFT;
            default:  state_nxt = ST_POST;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_POST;
      ST_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = (sts.kind_r == K_INSERT) ? ST_FILL : ST_POST;
        end
      end
      ST_FILL:  state_nxt = ST_POST;
      ST_POST: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_READ:  cmd.rd_issue = 1'b1;
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.del_finish = sts.shift_done && (sts.kind_r == K_DELETE);
      end
      ST_FILL:  cmd.fill = 1'b1;
      ST_POST:  cmd.post = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store testbench
// Drives opcodes into the list store in bursts while the result side stalls
// on a changing pattern, with long hold-offs to back the block up. Every
// accepted item is run through a shadow list kept here, and each result is
// compared field by field with the oldest outcome waiting. Stimulus covers
// an empty list, small lists churned at random, a longer list with shifts
// over many places, and a drain back down.
// ----------------------------------------------------------------------------
module testbench;
  import ils_pkg::*;

  localparam int LIST_CAP    = 1024;
  localparam int GROW_LEN    = 160;
  localparam int QUIET_LIMIT = 40000;
  localparam int PRINT_LIMIT = 40;

  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OpW-1:0]           opcode;
    logic [IndexW-1:0]        index;
    logic signed [ValueW-1:0] value;
  } list_op_t;

  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    logic                     read_hit;
    logic                     accepted;
    logic [LenW-1:0]          length;
  } list_outcome_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OpW-1:0]           in_opcode = '0;
  logic [IndexW-1:0]        in_item_index = '0;
  logic signed [ValueW-1:0] in_item_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ValueW-1:0] out_read_value;
  logic                     out_read_hit;
  logic                     out_accepted;
  logic [LenW-1:0]          out_list_length;

  list_op_t      ops_to_send[$];
  list_outcome_t outcomes_due[$];
  logic signed [ValueW-1:0] shadow_cells [LIST_CAP];
  int            shadow_len = 0;
  int            planned_len = 0;
  int            mismatch_count = 0;
  int            results_seen = 0;
  int            quiet_cycles = 0;
  logic          in_fire = 1'b0;

  list_op_t      send_op;
  int            burst_left = 0;
  int            gap_left = 0;

  stall_mode_t   stall_mode = STALL_NONE;
  int            mode_left = 0;
  int            hold_left = 0;
  bit            holdoff_done = 1'b0;

  list_op_t      took_op;
  list_outcome_t want, got;

  indexed_list_store #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_item_index  (in_item_index),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_read_hit   (out_read_hit),
    .out_accepted   (out_accepted),
    .out_list_length(out_list_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t ns result %0d: %s", $time, results_seen, msg);
    end
    mismatch_count++;
  endtask

  task automatic open_gap(input int pos, input logic signed [ValueW-1:0] value);
    for (int k = shadow_len; k > pos; k--) begin
      shadow_cells[k] = shadow_cells[k-1];
    end
    shadow_cells[pos] = value;
    shadow_len++;
  endtask

  task automatic apply_list_op(input list_op_t op, output list_outcome_t res);
    int  idx;
    bit  full;
    idx  = op.index;
    full = shadow_len >= LIST_CAP;
    res  = '0;
    case (op.opcode)
      OP_READ: begin
        if (idx < shadow_len) begin
          res.read_value = shadow_cells[idx];
          res.read_hit   = 1'b1;
        end
      end
      OP_INS_HEAD: begin
        if (!full) begin
          open_gap(0, op.value);
          res.accepted = 1'b1;
        end
      end
      OP_INS_TAIL: begin
        if (!full) begin
          open_gap(shadow_len, op.value);
          res.accepted = 1'b1;
        end
      end
      OP_INS_INDEX: begin
        if (idx <= shadow_len && !full) begin
          open_gap(idx, op.value);
          res.accepted = 1'b1;
        end
      end
      OP_DELETE: begin
        if (idx < shadow_len) begin
          for (int k = idx; k + 1 < shadow_len; k++) begin
            shadow_cells[k] = shadow_cells[k+1];
          end
          shadow_len--;
          res.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    res.length = shadow_len[LenW-1:0];
  endtask

  // Track the length the queued items will leave, so later items can aim at it.
  task automatic queue_op(input logic [OpW-1:0] opcode, input int idx,
                          input logic signed [ValueW-1:0] value);
    list_op_t op;
    if (idx > LIST_CAP) idx = LIST_CAP;
    if (idx < 0) idx = 0;
    op.opcode = opcode;
    op.index  = idx[IndexW-1:0];
    op.value  = value;
    ops_to_send.push_back(op);
    case (opcode)
      OP_INS_HEAD, OP_INS_TAIL: if (planned_len < LIST_CAP) planned_len++;
      OP_INS_INDEX: if (idx <= planned_len && planned_len < LIST_CAP) planned_len++;
      OP_DELETE: if (idx < planned_len) planned_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_index(input int len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, len);
    if (r < 80) return len;
    if (r < 88) return len + 1;
    if (r < 94) return LIST_CAP;
    return $urandom_range(0, LIST_CAP);
  endfunction

  task automatic queue_random_op(input int high_len);
    int r;
    int p_ins;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      queue_op(OpW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom_range(0, LIST_CAP),
               $urandom);
    end else if (r < 33) begin
      queue_op(OP_READ, pick_index(planned_len), $urandom);
    end else begin
      p_ins = (planned_len < 4) ? 80 : ((planned_len > high_len) ? 25 : 50);
      if ($urandom_range(0, 99) < p_ins) begin
        case ($urandom_range(0, 2))
          0:       queue_op(OP_INS_HEAD, $urandom_range(0, LIST_CAP), pick_value());
          1:       queue_op(OP_INS_TAIL, $urandom_range(0, LIST_CAP), pick_value());
          default: queue_op(OP_INS_INDEX, pick_index(planned_len), pick_value());
        endcase
      end else begin
        queue_op(OP_DELETE, pick_index(planned_len), $urandom);
      end
    end
  endtask

  // Sender: bursts of items separated by random gaps; hold a stalled item.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (ops_to_send.size() > 0) begin
        send_op = ops_to_send.pop_front();
        in_opcode     <= send_op.opcode;
        in_item_index <= send_op.index;
        in_item_value <= send_op.value;
        in_valid      <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a changing pattern, with long hold-offs now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 &&
          ((!holdoff_done && results_seen >= 60) || $urandom_range(0, 2999) == 0)) begin
        hold_left    = $urandom_range(300, 600);
        holdoff_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
          STALL_HEAVY: out_stall <= 1'($urandom_range(0, 1));
          default:     out_stall <= ((mode_left % 5) < 2);
        endcase
      end
    end
  end

  // Monitor: check results against the oldest outcome due, then predict.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid && !out_stall) begin
        got.read_value = out_read_value;
        got.read_hit   = out_read_hit;
        got.accepted   = out_accepted;
        got.length     = out_list_length;
        if (outcomes_due.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = outcomes_due.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, want %h", got.read_value, want.read_value));
          if (got.read_hit !== want.read_hit)
            report_mismatch($sformatf("read_hit %b, want %b", got.read_hit, want.read_hit));
          if (got.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, want %b", got.accepted, want.accepted));
          if (got.length !== want.length)
            report_mismatch($sformatf("list_length %0d, want %0d", got.length, want.length));
        end
        results_seen++;
        quiet_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        took_op.opcode = in_opcode;
        took_op.index  = in_item_index;
        took_op.value  = in_item_value;
        apply_list_op(took_op, want);
        outcomes_due.push_back(want);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    // empty list
    queue_op(OP_READ, 0, 32'h1234_5678);
    queue_op(OP_READ, LIST_CAP, 32'hFFFF_FFFF);
    queue_op(OP_DELETE, 0, 32'hFFFF_FFFF);
    queue_op(OP_INS_INDEX, 1, 32'h0BAD_F00D);
    // build a short list through every insert form
    queue_op(OP_INS_INDEX, 0, 32'h8000_0000);
    queue_op(OP_INS_HEAD, LIST_CAP, 32'h7FFF_FFFF);
    queue_op(OP_INS_TAIL, LIST_CAP, 32'hFFFF_FFFF);
    queue_op(OP_INS_INDEX, planned_len, 32'h0000_0000);
    queue_op(OP_INS_INDEX, 1, 32'h5555_5555);
    queue_op(OP_INS_HEAD, 0, 32'hAAAA_AAAA);
    queue_op(OP_READ, 0, 32'h0);
    queue_op(OP_READ, planned_len - 1, 32'h0);
    queue_op(OP_READ, planned_len, 32'h0);
    queue_op(OP_READ, LIST_CAP, 32'h0);
    queue_op(OP_DELETE, planned_len, 32'h0);
    queue_op(OP_DELETE, LIST_CAP, 32'h0);
    queue_op(OP_DELETE, 2, 32'h0);
    queue_op(OP_DELETE, 0, 32'h0);
    queue_op(OP_INS_INDEX, LIST_CAP, 32'h1);
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
      queue_op(OpW'(op), LIST_CAP, 32'hFFFF_FFFF);
    end
    queue_op(OP_DELETE, planned_len - 1, 32'h0);
    queue_op(OP_READ, 1, 32'h0);

    repeat (200) queue_random_op(40);

    // grow a longer list, mostly with cheap appends
    while (planned_len < GROW_LEN) begin
      case ($urandom_range(0, 9))
        0:       queue_op(OP_READ, $urandom_range(0, planned_len), $urandom);
        1, 2, 3, 4: queue_op(OP_INS_TAIL, $urandom_range(0, LIST_CAP), pick_value());
        default: queue_op(OP_INS_INDEX, planned_len, pick_value());
      endcase
    end
    queue_op(OP_INS_HEAD, 0, 32'h1111_1111);
    queue_op(OP_INS_TAIL, 0, 32'h2222_2222);
    queue_op(OP_INS_INDEX, 0, 32'h3333_3333);
    queue_op(OP_INS_INDEX, planned_len / 2, 32'h4444_4444);
    queue_op(OP_INS_INDEX, LIST_CAP, 32'h6666_6666);
    queue_op(OP_READ, 0, 32'h0);
    queue_op(OP_READ, planned_len - 1, 32'h0);
    queue_op(OP_READ, planned_len, 32'h0);
    queue_op(OP_DELETE, LIST_CAP, 32'h0);
    queue_op(OP_DELETE, planned_len - 1, 32'h0);
    queue_op(OP_INS_INDEX, planned_len - 1, 32'h8000_0000);
    queue_op(OP_INS_TAIL, 0, 32'h7777_7777);
    queue_op(OP_DELETE, 0, 32'h0);
    queue_op(OP_INS_HEAD, 0, 32'h7FFF_FFFF);
    queue_op(OP_INS_HEAD, 0, 32'h9999_9999);
    repeat (16) begin
      if ($urandom_range(0, 3) == 0)
        queue_op(OP_INS_INDEX, $urandom_range(0, planned_len + 1), pick_value());
      else
        queue_op(OP_READ, $urandom_range(0, LIST_CAP), $urandom);
    end

    // drain from the tail end
    while (planned_len > 12) begin
      if ($urandom_range(0, 7) == 0)
        queue_op(OP_READ, $urandom_range(0, LIST_CAP), $urandom);
      else
        queue_op(OP_DELETE, planned_len - 1 - $urandom_range(0, 2), $urandom);
    end

    repeat (150) queue_random_op(24);

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (ops_to_send.size() != 0 || in_valid) @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (LIST_CAP + 20) @(posedge clk);
    if (mismatch_count == 0 && outcomes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ils_pkg.sv
rtl/core/ils_ram.sv
rtl/core/ils_datapath.sv
rtl/core/ils_controller.sv
rtl/core/indexed_list_store.sv
tb/sv/testbench.sv
